// ===== hdl/vrt_pkg.sv =====
// Package with the shared types and constants of the voxel ray traversal block.
`timescale 1ns / 1ps
package vrt_pkg;

    // Longest run of cells that one ray yields.
    localparam int MAX_RUN = 64;
    localparam int RUN_W = $clog2(MAX_RUN + 1);

    // Reset value of the distance limit, in whole voxels.
    localparam logic [4:0] MAX_DIST_RESET = 5'd8;

    // Quotient bits of one setup division.
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Distance that is never reached.
    localparam logic [31:0] NEVER = 32'hFFFF_FFFF;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Face normal codes.
    localparam logic signed [1:0] NORMAL_POS  = 2'sb01;
    localparam logic signed [1:0] NORMAL_NEG  = 2'sb11;
    localparam logic signed [1:0] NORMAL_NONE = 2'sb00;

    // Per-axis distances, Q16.16.
    typedef logic [2:0][31:0] cross_vec_t;

    // Result of one traversal step.
    typedef struct packed {
        logic [1:0]  axis;
        logic [31:0] sum;
    } step_res_t;

endpackage

// ===== hdl/vrt_ifs.sv =====
// Channel interfaces of the voxel ray traversal block.
`timescale 1ns / 1ps
interface vrt_ray_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface vrt_voxel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    logic signed [1:0]  normal_z;
    logic               last;

    modport source (output valid, cell_x, cell_y, cell_z, normal_x, normal_y, normal_z,
                    last, input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, normal_x, normal_y, normal_z,
                  last, output ready);
endinterface

interface vrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/voxel_ray_traversal_top.sv =====
// Top level of the voxel ray traversal block: setup sequencer and step loop.
//
// The block walks a ray through a unit voxel grid. A request on the ray
// channel carries a Q15.8 origin and a Q1.14 unit direction. The voxel
// channel returns the cells crossed, in order, each with the normal of the
// face it was entered through; the start cell has a zero normal and the
// final cell of a run has last set. A run ends when the next boundary lies
// beyond max_distance voxels or after MAX_RUN cells.
// The cfg channel writes max_distance and is always ready; the user must
// write it only while the block is idle, as the block does not enforce it.
// Setup runs six divisions on one shared radix-2 divider; the two divisions
// of an axis are skipped for a zero direction component. After that each
// cell takes a step state (S_STEP) and then an output state (S_OUT), which
// it holds while the receiver stalls. One ray is handled at a time; ray.ready is
// high only while idle. A stalled receiver holds the result in the output
// register and the walk waits. Reset returns to idle with max_distance 8.
`timescale 1ns / 1ps
module voxel_ray_traversal_top
(
    input  logic       clk,
    input  logic       rst_n,
    vrt_ray_if.sink    ray,
    vrt_voxel_if.source voxel,
    vrt_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_STEP,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [4:0]                  max_dist_reg;
    logic [1:0]                  ax_reg;
    logic                        phase_reg;
    logic [vrt_pkg::RUN_W-1:0]   n_reg;
    logic                        stop_reg;
    logic [1:0]                  step_ax_reg;
    logic [2:0]                  sign_reg;
    logic [15:0]                 mag_reg  [3];
    logic [8:0]                  span_reg [3];
    logic [15:0]                 cell_reg [3];
    vrt_pkg::cross_vec_t         nc_reg;
    vrt_pkg::cross_vec_t         cs_reg;
    logic signed [15:0]          out_cell_reg   [3];
    logic signed [1:0]           out_normal_reg [3];

    logic               div_start;
    logic               div_done;
    logic [30:0]        dividend;
    logic [30:0]        quotient;
    vrt_pkg::step_res_t step_res;
    logic               ray_acc;
    logic               out_last;
    logic [23:0]        org_in [3];
    logic [15:0]        dir_in [3];

    assign org_in[0] = ray.origin_x;
    assign org_in[1] = ray.origin_y;
    assign org_in[2] = ray.origin_z;
    assign dir_in[0] = ray.dir_x;
    assign dir_in[1] = ray.dir_y;
    assign dir_in[2] = ray.dir_z;

    assign ray.ready = (state_reg == S_IDLE);
    assign ray_acc   = ray.valid && ray.ready;
    assign cfg.ready = 1'b1;

    // First crossing on phase zero, boundary spacing on phase one.
    assign dividend  = phase_reg ? {1'b1, 30'd0} : {span_reg[ax_reg], 22'd0};
    assign div_start = (state_reg == S_DIV_START) && (mag_reg[ax_reg] != 16'd0);

    vrt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (mag_reg[ax_reg]),
        .done     (div_done),
        .quotient (quotient)
    );

    vrt_step u_step
    (
        .next_cross (nc_reg),
        .cross_step (cs_reg),
        .res        (step_res)
    );

    assign out_last = stop_reg || (n_reg == vrt_pkg::RUN_W'(vrt_pkg::MAX_RUN));

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_dist_reg <= vrt_pkg::MAX_DIST_RESET;
            ax_reg       <= vrt_pkg::AXIS_X;
            phase_reg    <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                max_dist_reg <= cfg.data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ray_acc)
                    begin
                        ax_reg    <= vrt_pkg::AXIS_X;
                        phase_reg <= 1'b0;
                        n_reg     <= vrt_pkg::RUN_W'(1);
                        state_reg <= S_DIV_START;
                    end
                end
                S_DIV_START:
                begin
                    if (mag_reg[ax_reg] == 16'd0)
                    begin
                        if (ax_reg == vrt_pkg::AXIS_Z)
                        begin
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        phase_reg <= !phase_reg;
                        if (!phase_reg)
                        begin
                            state_reg <= S_DIV_START;
                        end
                        else if (ax_reg == vrt_pkg::AXIS_Z)
                        begin
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_STEP:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (voxel.ready)
                    begin
                        if (out_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= S_STEP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Ray state and output payload.
    always_ff @(posedge clk)
    begin
        if (ray_acc)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sign_reg[a]       <= dir_in[a][15] || (dir_in[a] == 16'd0);
                mag_reg[a]        <= dir_in[a][15] ? 16'(-dir_in[a]) : dir_in[a];
                span_reg[a]       <= dir_in[a][15] ? {1'b0, org_in[a][7:0]}
                                                   : (9'd256 - {1'b0, org_in[a][7:0]});
                cell_reg[a]       <= org_in[a][23:8];
                out_cell_reg[a]   <= org_in[a][23:8];
                out_normal_reg[a] <= vrt_pkg::NORMAL_NONE;
            end
        end

        // Zero direction component: the axis is never taken.
        if (state_reg == S_DIV_START && mag_reg[ax_reg] == 16'd0)
        begin
            nc_reg[ax_reg] <= vrt_pkg::NEVER;
            cs_reg[ax_reg] <= vrt_pkg::NEVER;
        end

        if (state_reg == S_DIV_WAIT && div_done)
        begin
            if (phase_reg)
            begin
                cs_reg[ax_reg] <= {1'b0, quotient};
            end
            else
            begin
                nc_reg[ax_reg] <= {1'b0, quotient};
            end
        end

        // One step toward the next cell.
        if (state_reg == S_STEP)
        begin
            step_ax_reg             <= step_res.axis;
            nc_reg[step_res.axis]   <= step_res.sum;
            cell_reg[step_res.axis] <= sign_reg[step_res.axis]
                                       ? cell_reg[step_res.axis] - 16'd1
                                       : cell_reg[step_res.axis] + 16'd1;
            stop_reg <= step_res.sum > {11'd0, max_dist_reg, 16'd0};
        end

        // Load the stepped cell once the previous one is taken.
        if (state_reg == S_OUT && voxel.ready && !out_last)
        begin
            for (int a = 0; a < 3; a++)
            begin
                out_cell_reg[a] <= cell_reg[a];
                if (2'(a) == step_ax_reg)
                begin
                    out_normal_reg[a] <= sign_reg[a] ? vrt_pkg::NORMAL_POS
                                                     : vrt_pkg::NORMAL_NEG;
                end
                else
                begin
                    out_normal_reg[a] <= vrt_pkg::NORMAL_NONE;
                end
            end
        end
    end

    assign voxel.valid    = (state_reg == S_OUT);
    assign voxel.cell_x   = out_cell_reg[0];
    assign voxel.cell_y   = out_cell_reg[1];
    assign voxel.cell_z   = out_cell_reg[2];
    assign voxel.normal_x = out_normal_reg[0];
    assign voxel.normal_y = out_normal_reg[1];
    assign voxel.normal_z = out_normal_reg[2];
    assign voxel.last     = out_last;

endmodule

// ===== hdl/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the ray setup.
`timescale 1ns / 1ps
module vrt_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [30:0] quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [vrt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [16:0]                   rem_reg;
    logic [30:0]                   dq_reg;
    logic [15:0]                   div_reg;

    logic [16:0] trial;
    logic        fits;

    // Shift the next dividend bit into the remainder and try the subtraction.
    assign trial = {rem_reg[15:0], dq_reg[30]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == vrt_pkg::DIV_CNT_W'(vrt_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            dq_reg  <= {dq_reg[29:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== hdl/vrt_step.sv =====
// Traversal step unit: picks the nearest boundary and advances its distance.
`timescale 1ns / 1ps
module vrt_step
(
    input  vrt_pkg::cross_vec_t next_cross,
    input  vrt_pkg::cross_vec_t cross_step,
    output vrt_pkg::step_res_t  res
);

    logic [1:0]  axis;
    logic [32:0] wide;

    // Nearest boundary; ties go to X, then Y.
    always_comb
    begin
        if (next_cross[0] <= next_cross[1] && next_cross[0] <= next_cross[2])
        begin
            axis = vrt_pkg::AXIS_X;
        end
        else if (next_cross[1] <= next_cross[2])
        begin
            axis = vrt_pkg::AXIS_Y;
        end
        else
        begin
            axis = vrt_pkg::AXIS_Z;
        end
    end

    // Saturating add of the boundary spacing.
    assign wide     = {1'b0, next_cross[axis]} + {1'b0, cross_step[axis]};
    assign res.axis = axis;
    assign res.sum  = wide[32] ? vrt_pkg::NEVER : wide[31:0];

endmodule
